FILE: sv/rusr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Session receiver package
// Shared constants for the reliable-UDP session receiver.
// ----------------------------------------------------------------------------
package rusr_pkg;

    localparam int unsigned SEEN_WINDOW_DEF  = 1024;
    localparam int unsigned MAX_DATAGRAM_DEF = 2048;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_PACKET = 2'd1;
    localparam logic [1:0] ACT_DOWN   = 2'd2;

    localparam logic [1:0] MODE_DISC       = 2'd0;
    localparam logic [1:0] MODE_CONNECTING = 2'd1;
    localparam logic [1:0] MODE_CONNECTED  = 2'd2;

    localparam logic [2:0] DROP_NONE    = 3'd0;
    localparam logic [2:0] DROP_CORRUPT = 3'd1;
    localparam logic [2:0] DROP_STALE   = 3'd2;
    localparam logic [2:0] DROP_SYN     = 3'd3;
    localparam logic [2:0] DROP_DUP     = 3'd4;
    localparam logic [2:0] DROP_REJECT  = 3'd5;

    localparam logic [1:0] REG_RETRY   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_HELLO   = 2'd2;

    localparam logic [7:0]  STATUS_ACCEPT = 8'h02;
    localparam logic [7:0]  STATUS_REJECT = 8'h04;
    localparam logic [15:0] EMPTY_ACK_SEQ = 16'h0061;

endpackage
`default_nettype wire

FILE: sv/reliable_udp_session_receiver.sv
`default_nettype none
// A tick, link-down word or dropped packet passes through the DIFF, PRE and OUT states.
// A packet that needs the duplicate check passes through DIFF, PRE, SCAN, CMP, POST and OUT,
// scanning up to SEEN_WINDOW stored IDs in CMP: each stored ID is read and then compared.
// One word at a time: a new word is accepted only in the idle state once the previous
// result word has been taken.
// Reset clears all session state; the seen-ID memory is never cleared, only its fill count and oldest pointer.
// ----------------------------------------------------------------------------
// Reliable-UDP session receiver
// Client side session handling with a sequential duplicate scan of seen IDs.
// ----------------------------------------------------------------------------
module reliable_udp_session_receiver
    import rusr_pkg::*;
#(
    parameter int unsigned SEEN_WINDOW  = SEEN_WINDOW_DEF,
    parameter int unsigned MAX_DATAGRAM = MAX_DATAGRAM_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] now_ms,
    input  wire logic [11:0] packet_size,
    input  wire logic [15:0] header_word,
    input  wire logic [15:0] packet_session,
    input  wire logic [15:0] remote_packet_id,
    input  wire logic [7:0]  status_byte,
    input  wire logic        payload_well_formed,
    input  wire logic [7:0]  segment_count,
    input  wire logic        has_init_complete,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             send_hello,
    output logic             send_ack,
    output logic [15:0]      ack_session,
    output logic [15:0]      ack_packet_id,
    output logic [15:0]      ack_sequence_field,
    output logic             deliver_payload,
    output logic             send_time_request,
    output logic [1:0]       link_state,
    output logic [2:0]       drop_reason
);

    localparam int unsigned IW = $clog2(SEEN_WINDOW);
    localparam int unsigned FW = IW + 1;
    localparam logic [FW-1:0] FULL = FW'(SEEN_WINDOW);
    localparam logic [11:0] MAXD = 12'(MAX_DATAGRAM);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_DIFF  = 3'd6;

    logic [2:0]  state_reg;

    // Configuration registers.
    logic [15:0] retry_reg, timeout_reg, hello_reg;

    // Captured input word.
    logic [1:0]  act_reg;
    logic [31:0] now_reg;
    logic [11:0] size_reg;
    logic [15:0] hdr_reg, psess_reg, rid_reg;
    logic [7:0]  status_reg, segs_reg;
    logic        wf_reg, initc_reg;

    // Session state.
    logic [1:0]  mode_reg;
    logic [15:0] session_reg;
    logic [31:0] attempt_reg, heard_reg;
    logic [15:0] last_rid_reg;
    logic        awaiting_reg, sync_reg, seen_state_reg, empty_reg;
    logic        recov_reg, treq_pend_reg;
    logic [15:0] segsum_reg;
    logic [FW-1:0] fill_reg;
    logic [IW-1:0] oldest_reg;

    // Scan control.
    logic [FW-1:0] scan_reg;
    logic          hit_reg;
    logic          rd_pend_reg;
    logic          is_dup_reg;

    // Shared subtract/compare unit result.
    logic          late_reg;

    // Result word.
    logic        r_hello_reg, r_ack_reg, r_deliver_reg, r_treq_reg;
    logic [15:0] r_sess_reg, r_id_reg, r_seq_reg;
    logic [2:0]  r_drop_reg;
    logic        out_valid_reg;

    // Seen-ID memory.
    logic [15:0] seen_mem [SEEN_WINDOW];
    logic [15:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] wr_addr;

    // Shared unit: one 32-bit subtract and a compare against a 16-bit limit.
    logic [31:0] diff_base;
    logic [15:0] diff_lim;
    logic [31:0] diff;

    // Decoded header fields.
    logic [11:0] size_c;
    logic [7:0]  flags;
    logic        syn, reliable, retrans, cmds, len_bad;

    assign size_c   = (size_reg > MAXD) ? MAXD : size_reg;
    assign flags    = hdr_reg[15:8] & 8'hF8;
    assign syn      = flags[4];
    assign reliable = flags[3];
    assign retrans  = flags[5];
    assign cmds     = (size_c > 12'd12) && wf_reg;
    assign len_bad  = (size_c < 12'd12) || ({1'b0, hdr_reg[10:0]} != size_c);

    always_comb
    begin
        diff_base = attempt_reg;
        diff_lim  = retry_reg;
        if (mode_reg == MODE_CONNECTED)
        begin
            diff_base = heard_reg;
            diff_lim  = timeout_reg;
        end
        diff = now_reg - diff_base;
    end

    assign rd_addr = IW'({1'b0, oldest_reg} + {1'b0, scan_reg[IW-1:0]});

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    assign send_hello         = r_hello_reg;
    assign send_ack           = r_ack_reg;
    assign ack_session        = r_sess_reg;
    assign ack_packet_id      = r_id_reg;
    assign ack_sequence_field = r_seq_reg;
    assign deliver_payload    = r_deliver_reg;
    assign send_time_request  = r_treq_reg;
    assign link_state         = mode_reg;
    assign drop_reason        = r_drop_reg;

    // Memory write happens in the post-processing step for a new ID.
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = oldest_reg;
        if (state_reg == ST_POST && !is_dup_reg && !syn)
        begin
            mem_we = 1'b1;
            if (fill_reg != FULL)
            begin
                wr_addr = IW'({1'b0, oldest_reg} + fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[wr_addr] <= rid_reg;
        end
        rd_data_reg <= seen_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            retry_reg      <= 16'd2000;
            timeout_reg    <= 16'd5000;
            hello_reg      <= 16'h53AB;
            mode_reg       <= MODE_DISC;
            session_reg    <= '0;
            attempt_reg    <= '0;
            heard_reg      <= '0;
            last_rid_reg   <= '0;
            awaiting_reg   <= 1'b0;
            sync_reg       <= 1'b0;
            seen_state_reg <= 1'b0;
            empty_reg      <= 1'b0;
            recov_reg      <= 1'b0;
            treq_pend_reg  <= 1'b0;
            segsum_reg     <= '0;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            scan_reg       <= '0;
            hit_reg        <= 1'b0;
            rd_pend_reg    <= 1'b0;
            is_dup_reg     <= 1'b0;
            late_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            r_hello_reg    <= 1'b0;
            r_ack_reg      <= 1'b0;
            r_deliver_reg  <= 1'b0;
            r_treq_reg     <= 1'b0;
            r_sess_reg     <= '0;
            r_id_reg       <= '0;
            r_seq_reg      <= '0;
            r_drop_reg     <= DROP_NONE;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RETRY:   retry_reg   <= cfg_data;
                    REG_TIMEOUT: timeout_reg <= cfg_data;
                    REG_HELLO:   hello_reg   <= cfg_data;
                    default:     ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        act_reg    <= action;
                        now_reg    <= now_ms;
                        size_reg   <= packet_size;
                        hdr_reg    <= header_word;
                        psess_reg  <= packet_session;
                        rid_reg    <= remote_packet_id;
                        status_reg <= status_byte;
                        wf_reg     <= payload_well_formed;
                        segs_reg   <= segment_count;
                        initc_reg  <= has_init_complete;
                        state_reg  <= ST_DIFF;
                    end
                end

                // Shared unit evaluates the elapsed-time compare.
                ST_DIFF:
                begin
                    late_reg  <= diff > {16'd0, diff_lim};
                    r_hello_reg   <= 1'b0;
                    r_ack_reg     <= 1'b0;
                    r_deliver_reg <= 1'b0;
                    r_treq_reg    <= 1'b0;
                    r_sess_reg    <= '0;
                    r_id_reg      <= '0;
                    r_seq_reg     <= '0;
                    r_drop_reg    <= DROP_NONE;
                    state_reg     <= ST_PRE;
                end

                // Everything up to the duplicate check.
                ST_PRE:
                begin
                    state_reg <= ST_OUT;
                    if (act_reg == ACT_TICK)
                    begin
                        if (mode_reg == MODE_DISC)
                        begin
                            if (late_reg)
                            begin
                                last_rid_reg   <= '0;
                                session_reg    <= hello_reg;
                                awaiting_reg   <= 1'b0;
                                sync_reg       <= 1'b0;
                                seen_state_reg <= 1'b0;
                                empty_reg      <= 1'b0;
                                recov_reg      <= 1'b0;
                                treq_pend_reg  <= 1'b0;
                                fill_reg       <= '0;
                                oldest_reg     <= '0;
                                segsum_reg     <= '0;
                                attempt_reg    <= now_reg;
                                mode_reg       <= MODE_CONNECTING;
                                r_hello_reg    <= 1'b1;
                            end
                        end
                        else if (late_reg)
                        begin
                            mode_reg <= MODE_DISC;
                        end
                    end
                    else if (act_reg == ACT_DOWN)
                    begin
                        mode_reg       <= MODE_DISC;
                        heard_reg      <= '0;
                        attempt_reg    <= now_reg;
                        awaiting_reg   <= 1'b0;
                        sync_reg       <= 1'b0;
                        seen_state_reg <= 1'b0;
                        empty_reg      <= 1'b0;
                        recov_reg      <= 1'b0;
                        treq_pend_reg  <= 1'b0;
                        fill_reg       <= '0;
                        oldest_reg     <= '0;
                    end
                    else if (act_reg == ACT_PACKET && mode_reg == MODE_CONNECTING)
                    begin
                        if (len_bad)
                        begin
                            r_drop_reg <= DROP_CORRUPT;
                        end
                        else if (size_c >= 12'd13 && syn)
                        begin
                            if (status_reg == STATUS_ACCEPT)
                            begin
                                session_reg  <= psess_reg;
                                last_rid_reg <= rid_reg;
                                r_ack_reg    <= 1'b1;
                                r_sess_reg   <= psess_reg;
                                r_id_reg     <= rid_reg;
                                awaiting_reg <= 1'b1;
                                mode_reg     <= MODE_CONNECTED;
                                heard_reg    <= now_reg;
                            end
                            else
                            begin
                                mode_reg   <= MODE_DISC;
                                r_drop_reg <= DROP_REJECT;
                            end
                        end
                    end
                    else if (act_reg == ACT_PACKET && mode_reg == MODE_CONNECTED)
                    begin
                        if (late_reg)
                        begin
                            mode_reg <= MODE_DISC;
                        end
                        else if (len_bad)
                        begin
                            r_drop_reg <= DROP_CORRUPT;
                            if (treq_pend_reg)
                            begin
                                treq_pend_reg <= 1'b0;
                                r_treq_reg    <= 1'b1;
                            end
                        end
                        else
                        begin : sess_blk
                            logic [15:0]   sess;
                            logic          aw, rec;
                            logic          stale;
                            logic [FW-1:0] fl;
                            logic [IW-1:0] ol;
                            sess  = session_reg;
                            aw    = awaiting_reg;
                            rec   = recov_reg;
                            fl    = fill_reg;
                            ol    = oldest_reg;
                            stale = 1'b0;
                            if (aw && !syn)
                            begin
                                sess = psess_reg;
                                aw   = 1'b0;
                                fl   = '0;
                                ol   = '0;
                            end
                            if (psess_reg != sess)
                            begin
                                if (!syn && !sync_reg && !rec && cmds &&
                                    (reliable || segsum_reg == 16'd0))
                                begin
                                    sess = psess_reg;
                                    rec  = 1'b1;
                                    aw   = 1'b0;
                                    fl   = '0;
                                    ol   = '0;
                                end
                                else
                                begin
                                    stale = 1'b1;
                                end
                            end
                            session_reg  <= sess;
                            awaiting_reg <= aw;
                            recov_reg    <= rec;
                            fill_reg     <= fl;
                            oldest_reg   <= ol;
                            r_sess_reg   <= sess;
                            if (stale)
                            begin
                                r_drop_reg <= DROP_STALE;
                                if (treq_pend_reg)
                                begin
                                    treq_pend_reg <= 1'b0;
                                    r_treq_reg    <= 1'b1;
                                end
                            end
                            else
                            begin
                                heard_reg    <= now_reg;
                                last_rid_reg <= rid_reg;
                                if (syn)
                                begin
                                    if (size_c > 12'd12 && status_reg == STATUS_REJECT)
                                    begin
                                        mode_reg   <= MODE_DISC;
                                        r_drop_reg <= DROP_REJECT;
                                    end
                                    else
                                    begin
                                        r_drop_reg <= DROP_SYN;
                                        if (treq_pend_reg)
                                        begin
                                            treq_pend_reg <= 1'b0;
                                            r_treq_reg    <= 1'b1;
                                        end
                                    end
                                end
                                else
                                begin
                                    // Start the scan of stored IDs.
                                    scan_reg    <= '0;
                                    hit_reg     <= 1'b0;
                                    rd_pend_reg <= 1'b0;
                                    state_reg   <= ST_SCAN;
                                end
                            end
                        end
                    end
                end

                // Issue the first read; the address follows scan_reg.
                ST_SCAN:
                begin
                    rd_pend_reg <= 1'b0;
                    state_reg   <= ST_CMP;
                end

                // One stored ID is read and then compared.
                ST_CMP:
                begin
                    if (scan_reg >= fill_reg || hit_reg)
                    begin
                        is_dup_reg <= hit_reg;
                        state_reg  <= ST_POST;
                    end
                    else if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        if (rd_data_reg == rid_reg)
                        begin
                            hit_reg <= 1'b1;
                        end
                        else
                        begin
                            scan_reg <= scan_reg + FW'(1);
                        end
                        rd_pend_reg <= 1'b0;
                    end
                end

                // Acknowledge, delivery and flag updates.
                ST_POST:
                begin : post_blk
                    logic        tp, sd;
                    logic [16:0] sum;
                    tp = treq_pend_reg;
                    sd = sync_reg;
                    state_reg <= ST_OUT;
                    if (retrans && is_dup_reg)
                    begin
                        if (reliable)
                        begin
                            r_ack_reg <= 1'b1;
                            r_id_reg  <= rid_reg;
                        end
                        r_drop_reg <= DROP_DUP;
                    end
                    else
                    begin
                        if (!is_dup_reg)
                        begin
                            if (fill_reg != FULL)
                            begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                            else
                            begin
                                oldest_reg <= oldest_reg + IW'(1);
                            end
                        end
                        if (reliable)
                        begin
                            r_ack_reg <= 1'b1;
                            r_id_reg  <= rid_reg;
                            if (size_c == 12'd12 && !empty_reg)
                            begin
                                r_seq_reg <= EMPTY_ACK_SEQ;
                                empty_reg <= 1'b1;
                                if (!sd)
                                begin
                                    sd = 1'b1;
                                    seen_state_reg <= 1'b1;
                                    tp = 1'b1;
                                end
                            end
                        end
                        if (cmds)
                        begin
                            r_deliver_reg <= 1'b1;
                            sum = {1'b0, segsum_reg} + {9'd0, segs_reg};
                            segsum_reg <= sum[16] ? 16'hFFFF : sum[15:0];
                            if (initc_reg)
                            begin
                                sd = 1'b1;
                                tp = 1'b1;
                            end
                            seen_state_reg <= 1'b1;
                        end
                    end
                    sync_reg      <= sd;
                    r_treq_reg    <= tp;
                    treq_pend_reg <= 1'b0;
                end

                // Present the result word.
                ST_OUT:
                begin
                    if (!r_ack_reg)
                    begin
                        r_sess_reg <= '0;
                        r_id_reg   <= '0;
                        r_seq_reg  <= '0;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sim/tb_reliable_udp_session_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Session receiver testbench
// Drives ticks, packet headers and link-down words through the valid/ready
// input and checks every result word against a cycle-free session predictor.
// Traffic is mostly complete sessions (hello, SYN accept, data, acknowledges,
// retransmissions) with random content, plus noise and broken sequences.
// ----------------------------------------------------------------------------
module tb_reliable_udp_session_receiver;
    import rusr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam logic [7:0] FLAG_RELIABLE = 8'h08;
    localparam logic [7:0] FLAG_SYN      = 8'h10;
    localparam logic [7:0] FLAG_RETRANS  = 8'h20;
    localparam int         WORD_TARGET   = 570;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [11:0] packet_size;
        logic [15:0] header_word;
        logic [15:0] packet_session;
        logic [15:0] remote_packet_id;
        logic [7:0]  status_byte;
        logic        payload_well_formed;
        logic [7:0]  segment_count;
        logic        has_init_complete;
    } word_t;

    typedef struct packed {
        logic        send_hello;
        logic        send_ack;
        logic [15:0] ack_session;
        logic [15:0] ack_packet_id;
        logic [15:0] ack_sequence_field;
        logic        deliver_payload;
        logic        send_time_request;
        logic [1:0]  link_state;
        logic [2:0]  drop_reason;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    word_t       drv;
    logic        out_valid;
    logic        out_ready;
    result_t     mon;

    word_t   pending_words[$];
    result_t expected_results[$];
    int      fail_count;
    int      words_sent;
    logic    took;
    logic    hold_request;

    // Predictor state and configuration copy.
    logic [15:0] cfg_retry, cfg_timeout, cfg_hello;
    logic [1:0]  p_mode;
    logic [15:0] p_session, p_last_rid;
    logic [31:0] p_attempt_ms, p_heard_ms;
    logic        p_awaiting, p_sync_done, p_state_seen, p_empty_acked;
    logic        p_recovered, p_treq_pending;
    int unsigned p_segments;
    logic [15:0] p_seen_ids [0:SEEN_WINDOW_DEF-1];
    int unsigned p_seen_fill, p_seen_oldest;
    int          n_hello, n_ack, n_dup, n_deliver, n_stale;

    // Stimulus generator time base.
    logic [31:0] gen_ms;

    reliable_udp_session_receiver u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .action              (drv.action),
        .now_ms              (drv.now_ms),
        .packet_size         (drv.packet_size),
        .header_word         (drv.header_word),
        .packet_session      (drv.packet_session),
        .remote_packet_id    (drv.remote_packet_id),
        .status_byte         (drv.status_byte),
        .payload_well_formed (drv.payload_well_formed),
        .segment_count       (drv.segment_count),
        .has_init_complete   (drv.has_init_complete),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .send_hello          (mon.send_hello),
        .send_ack            (mon.send_ack),
        .ack_session         (mon.ack_session),
        .ack_packet_id       (mon.ack_packet_id),
        .ack_sequence_field  (mon.ack_sequence_field),
        .deliver_payload     (mon.deliver_payload),
        .send_time_request   (mon.send_time_request),
        .link_state          (mon.link_state),
        .drop_reason         (mon.drop_reason)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The duplicate window, oldest entry first.
    function automatic bit seen_hit(logic [15:0] id);
        for (int unsigned i = 0; i < p_seen_fill; i++)
        begin
            if (p_seen_ids[(p_seen_oldest + i) % SEEN_WINDOW_DEF] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic seen_record(logic [15:0] id);
        if (!seen_hit(id))
        begin
            if (p_seen_fill < SEEN_WINDOW_DEF)
            begin
                p_seen_ids[(p_seen_oldest + p_seen_fill) % SEEN_WINDOW_DEF] = id;
                p_seen_fill++;
            end
            else
            begin
                p_seen_ids[p_seen_oldest] = id;
                p_seen_oldest = (p_seen_oldest + 1) % SEEN_WINDOW_DEF;
            end
        end
    endtask

    task automatic clear_session_flags();
        p_awaiting = 0; p_sync_done = 0; p_state_seen = 0;
        p_empty_acked = 0; p_recovered = 0; p_treq_pending = 0;
        p_seen_fill = 0; p_seen_oldest = 0;
    endtask

    // Works out the result word for one accepted word and advances the state.
    task automatic predict_session(input word_t w, output result_t r);
        logic [11:0] size;
        logic [7:0]  flags;
        logic        syn, reliable, cmds, stop;
        logic [7:0]  st;
        r = '0;
        size = (w.packet_size > MAX_DATAGRAM_DEF) ? 12'(MAX_DATAGRAM_DEF) : w.packet_size;
        flags = w.header_word[15:8] & 8'hF8;
        syn = (flags & FLAG_SYN) != 0;
        reliable = (flags & FLAG_RELIABLE) != 0;
        cmds = size > 12 && w.payload_well_formed;
        stop = 0;
        if (w.action == ACT_TICK)
        begin
            if (p_mode == MODE_DISC)
            begin
                if (w.now_ms - p_attempt_ms > {16'd0, cfg_retry})
                begin
                    p_last_rid = 0;
                    p_session = cfg_hello;
                    clear_session_flags();
                    p_segments = 0;
                    p_attempt_ms = w.now_ms;
                    p_mode = MODE_CONNECTING;
                    r.send_hello = 1;
                end
            end
            else if (p_mode == MODE_CONNECTING)
            begin
                if (w.now_ms - p_attempt_ms > {16'd0, cfg_retry})
                    p_mode = MODE_DISC;
            end
            else if (w.now_ms - p_heard_ms > {16'd0, cfg_timeout})
                p_mode = MODE_DISC;
        end
        else if (w.action == ACT_DOWN)
        begin
            p_mode = MODE_DISC;
            p_heard_ms = 0;
            p_attempt_ms = w.now_ms;
            clear_session_flags();
        end
        else if (w.action == ACT_PACKET && p_mode == MODE_CONNECTING)
        begin
            if (size < 12 || {1'b0, w.header_word[10:0]} != size)
                r.drop_reason = DROP_CORRUPT;
            else if (size >= 13 && syn)
            begin
                if (w.status_byte == STATUS_ACCEPT)
                begin
                    p_session = w.packet_session;
                    p_last_rid = w.remote_packet_id;
                    r.send_ack = 1;
                    r.ack_packet_id = w.remote_packet_id;
                    p_awaiting = 1;
                    p_mode = MODE_CONNECTED;
                    p_heard_ms = w.now_ms;
                end
                else
                begin
                    p_mode = MODE_DISC;
                    r.drop_reason = DROP_REJECT;
                end
            end
        end
        else if (w.action == ACT_PACKET && p_mode == MODE_CONNECTED)
        begin
            if (w.now_ms - p_heard_ms > {16'd0, cfg_timeout})
            begin
                p_mode = MODE_DISC;
                stop = 1;
            end
            else if (size < 12 || {1'b0, w.header_word[10:0]} != size)
                r.drop_reason = DROP_CORRUPT;
            else
            begin
                if (p_awaiting && !syn)
                begin
                    p_session = w.packet_session;
                    p_awaiting = 0;
                    p_seen_fill = 0; p_seen_oldest = 0;
                end
                if (w.packet_session != p_session)
                begin
                    if (!syn && !p_sync_done && !p_recovered && cmds
                        && (reliable || p_segments == 0))
                    begin
                        p_session = w.packet_session;
                        p_recovered = 1;
                        p_awaiting = 0;
                        p_seen_fill = 0; p_seen_oldest = 0;
                    end
                    else
                        r.drop_reason = DROP_STALE;
                end
                if (r.drop_reason == DROP_NONE)
                begin
                    p_heard_ms = w.now_ms;
                    p_last_rid = w.remote_packet_id;
                    if (syn)
                    begin
                        st = (size > 12) ? w.status_byte : 8'd0;
                        if (st == STATUS_REJECT)
                        begin
                            p_mode = MODE_DISC;
                            r.drop_reason = DROP_REJECT;
                            stop = 1;
                        end
                        else
                            r.drop_reason = DROP_SYN;
                    end
                    else if ((flags & FLAG_RETRANS) != 0 && seen_hit(w.remote_packet_id))
                    begin
                        if (reliable)
                        begin
                            r.send_ack = 1;
                            r.ack_packet_id = w.remote_packet_id;
                        end
                        r.drop_reason = DROP_DUP;
                    end
                    else
                    begin
                        seen_record(w.remote_packet_id);
                        if (reliable)
                        begin
                            r.send_ack = 1;
                            r.ack_packet_id = w.remote_packet_id;
                            if (size == 12 && !p_empty_acked)
                            begin
                                r.ack_sequence_field = EMPTY_ACK_SEQ;
                                p_empty_acked = 1;
                                if (!p_sync_done)
                                begin
                                    p_sync_done = 1;
                                    p_state_seen = 1;
                                    p_treq_pending = 1;
                                end
                            end
                        end
                        if (cmds)
                        begin
                            r.deliver_payload = 1;
                            p_segments += w.segment_count;
                            if (p_segments > 16'hFFFF)
                                p_segments = 16'hFFFF;
                            if (w.has_init_complete)
                            begin
                                p_sync_done = 1;
                                p_treq_pending = 1;
                            end
                            p_state_seen = 1;
                        end
                    end
                end
            end
            if (!stop && p_treq_pending)
            begin
                p_treq_pending = 0;
                r.send_time_request = 1;
            end
        end
        if (r.send_ack)
            r.ack_session = p_session;
        r.link_state = p_mode;
        n_hello += r.send_hello;
        n_ack += r.send_ack;
        n_deliver += r.deliver_payload;
        n_dup += (r.drop_reason == DROP_DUP);
        n_stale += (r.drop_reason == DROP_STALE);
    endtask

    // Word builders.
    function automatic word_t tick_word(logic [31:0] t, logic [1:0] act);
        word_t w;
        w = '0;
        w.action = act;
        w.now_ms = t;
        return w;
    endfunction

    function automatic word_t packet_word(logic [31:0] t, logic [11:0] size,
                                          logic [7:0] flags, logic [15:0] sess,
                                          logic [15:0] rid, logic [7:0] status,
                                          logic wf, logic [7:0] segs, logic initc);
        word_t w;
        w.action = ACT_PACKET;
        w.now_ms = t;
        w.packet_size = size;
        w.header_word = {flags[7:3], size[10:0]};
        w.packet_session = sess;
        w.remote_packet_id = rid;
        w.status_byte = status;
        w.payload_well_formed = wf;
        w.segment_count = segs;
        w.has_init_complete = initc;
        return w;
    endfunction

    task automatic queue_word(word_t w);
        pending_words.push_back(w);
        words_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RETRY:   cfg_retry = value;
            REG_TIMEOUT: cfg_timeout = value;
            REG_HELLO:   cfg_hello = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // One well-formed session with random content and the odd fault.
    task automatic queue_session();
        logic [15:0] sid, rid_base, rid;
        logic [11:0] size;
        logic [7:0]  flags;
        int          n, kind, step_max;
        sid = 16'($urandom);
        rid_base = 16'($urandom);
        step_max = (cfg_timeout < 20) ? cfg_timeout : 20;
        gen_ms += cfg_retry + 1 + $urandom_range(0, 5);
        queue_word(tick_word(gen_ms, ACT_TICK));
        gen_ms += $urandom_range(0, 2);
        size = 12'($urandom_range(13, 24));
        queue_word(packet_word(gen_ms, size, FLAG_SYN | 8'($urandom_range(0, 1) << 3), sid,
                               16'($urandom), STATUS_ACCEPT, 1'b0, 8'd0, 1'b0));
        n = $urandom_range(4, 25);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 99);
            gen_ms += $urandom_range(0, step_max);
            rid = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : rid_base + 16'($urandom_range(0, 15));
            size = 12'($urandom_range(13, 64));
            flags = ($urandom_range(0, 3) != 0 ? FLAG_RELIABLE : 8'h00)
                    | ($urandom_range(0, 3) == 0 ? FLAG_RETRANS : 8'h00);
            if (kind < 45)
                queue_word(packet_word(gen_ms, size, flags, sid, rid, 8'($urandom),
                                       $urandom_range(0, 7) != 0, 8'($urandom),
                                       $urandom_range(0, 9) == 0));
            else if (kind < 55)
                queue_word(packet_word(gen_ms, 12'd12, flags | FLAG_RELIABLE, sid, rid,
                                       8'd0, 1'($urandom), 8'($urandom), 1'b0));
            else if (kind < 63)
                queue_word(packet_word(gen_ms, size, flags, 16'($urandom), rid, 8'd0,
                                       1'b1, 8'($urandom_range(0, 3)), 1'($urandom)));
            else if (kind < 70)
            begin
                queue_word(packet_word(gen_ms, size, flags, sid, rid, 8'd0, 1'b1,
                                       8'd1, 1'b0));
                pending_words[$].header_word[10:0] = 11'($urandom_range(0, 11));
            end
            else if (kind < 76)
                queue_word(packet_word(gen_ms, 12'($urandom_range(12, 20)), FLAG_SYN | flags,
                                       sid, rid, ($urandom_range(0, 4) == 0) ? STATUS_REJECT
                                       : 8'($urandom), 1'b0, 8'd0, 1'b0));
            else if (kind < 82)
                queue_word(tick_word(gen_ms, ACT_TICK));
            else
                queue_word(packet_word(gen_ms, size, flags | FLAG_RETRANS, sid,
                                       rid_base + 16'($urandom_range(0, 15)), 8'd0,
                                       1'($urandom), 8'($urandom), 1'b0));
        end
        case ($urandom_range(0, 2))
            0: queue_word(tick_word(gen_ms + $urandom_range(0, 9), ACT_DOWN));
            1:
            begin
                gen_ms += cfg_timeout + 1;
                queue_word(tick_word(gen_ms, ACT_TICK));
            end
            default: ;
        endcase
    endtask

    // Random words, unknown action included; the time is often the generator time.
    task automatic queue_noise();
        word_t w;
        w = word_t'({$urandom, $urandom, $urandom, $urandom});
        w.now_ms = ($urandom_range(0, 1) != 0) ? gen_ms : $urandom;
        queue_word(w);
    endtask

    task automatic queue_directed();
        logic [31:0] t;
        t = 32'd0;
        queue_word(packet_word(t, 12'd13, FLAG_SYN, 16'h1234, 16'd1, STATUS_ACCEPT,
                               1'b0, 8'd0, 1'b0));
        queue_word(tick_word(t, ACT_UNKNOWN));
        t = 32'd2001;
        queue_word(tick_word(t, ACT_TICK));
        queue_word(packet_word(t, 12'd20, FLAG_RELIABLE, 16'h1234, 16'd2, 8'd0,
                               1'b1, 8'd3, 1'b0));
        queue_word(packet_word(t, 12'd5, FLAG_SYN, 16'h1234, 16'd2, 8'd0, 1'b0, 8'd0, 1'b0));
        queue_word(packet_word(t, 12'd13, FLAG_SYN, 16'h1234, 16'd3, 8'h07,
                               1'b0, 8'd0, 1'b0));
        t = 32'd4003;
        queue_word(tick_word(t, ACT_TICK));
        queue_word(packet_word(t, 12'd13, FLAG_SYN, 16'h1234, 16'd10, STATUS_ACCEPT,
                               1'b0, 8'd0, 1'b0));
        queue_word(packet_word(t + 1, 12'd12, FLAG_RELIABLE, 16'h1234, 16'd11, 8'd0,
                               1'b0, 8'd0, 1'b0));
        queue_word(packet_word(t + 2, 12'd2047, FLAG_RELIABLE, 16'h1234, 16'hFFFF, 8'hFF,
                               1'b1, 8'hFF, 1'b1));
        queue_word(packet_word(t + 3, 12'd40, FLAG_RELIABLE | FLAG_RETRANS, 16'h1234,
                               16'hFFFF, 8'd0, 1'b1, 8'd1, 1'b0));
        queue_word(packet_word(t + 4, 12'd40, FLAG_RELIABLE, 16'hFFFF, 16'd12, 8'd0,
                               1'b1, 8'd1, 1'b0));
        queue_word(packet_word(t + 5, 12'd12, FLAG_SYN, 16'h1234, 16'd13, 8'd0,
                               1'b0, 8'd0, 1'b0));
        queue_word(packet_word(t + 6, 12'd4095, 8'hF8, 16'h1234, 16'd14, 8'd0,
                               1'b1, 8'd0, 1'b0));
        queue_word(packet_word(t + 7, 12'd13, FLAG_SYN, 16'h1234, 16'd15, STATUS_REJECT,
                               1'b0, 8'd0, 1'b0));
        t = 32'd7000;
        queue_word(tick_word(t, ACT_TICK));
        queue_word(packet_word(t, 12'd13, FLAG_SYN, 16'h0000, 16'd0, STATUS_ACCEPT,
                               1'b0, 8'd0, 1'b0));
        queue_word(packet_word(t + 5001, 12'd12, FLAG_RELIABLE, 16'h0000, 16'd1, 8'd0,
                               1'b0, 8'd0, 1'b0));
        queue_word(tick_word(32'hFFFF_FFFF, ACT_DOWN));
        queue_word(tick_word(32'd1999, ACT_TICK));
        gen_ms = 32'd2000;
    endtask

    // Sender: bursts of words with random gaps between them.
    always @(negedge clk)
    begin : sender
        static int burst_left = 4;
        static int gap_left = 0;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !took)
            in_valid <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_words.size() != 0)
        begin
            drv <= pending_words.pop_front();
            in_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random stall pattern whose odds are redrawn at each new phase, with one long hold-off.
    always @(negedge clk)
    begin : receiver
        static int hold_left = 0;
        static int phase_cycle = 0;
        static int stall_odds = 0;
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 600;
        end
        phase_cycle++;
        if (phase_cycle % 64 == 0)
            stall_odds = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (stall_odds == 0) ? 1'b1 : ($urandom_range(0, 3) >= stall_odds);
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Acceptance, prediction and result comparison at the rising edge.
    always @(posedge clk)
    begin : monitor
        result_t r;
        result_t e;
        took <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_session(drv, r);
            expected_results.push_back(r);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("send_hello", e.send_hello, mon.send_hello);
                check_field("send_ack", e.send_ack, mon.send_ack);
                check_field("ack_session", e.ack_session, mon.ack_session);
                check_field("ack_packet_id", e.ack_packet_id, mon.ack_packet_id);
                check_field("ack_sequence_field", e.ack_sequence_field,
                            mon.ack_sequence_field);
                check_field("deliver_payload", e.deliver_payload, mon.deliver_payload);
                check_field("send_time_request", e.send_time_request,
                            mon.send_time_request);
                check_field("link_state", e.link_state, mon.link_state);
                check_field("drop_reason", e.drop_reason, mon.drop_reason);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int target;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        drv = '0;
        out_ready = 1'b0;
        took = 1'b0;
        hold_request = 1'b0;
        fail_count = 0;
        words_sent = 0;
        n_hello = 0; n_ack = 0; n_dup = 0; n_deliver = 0; n_stale = 0;
        cfg_retry = 16'd2000;
        cfg_timeout = 16'd5000;
        cfg_hello = 16'h53AB;
        p_mode = MODE_DISC;
        p_session = 0; p_last_rid = 0;
        p_attempt_ms = 0; p_heard_ms = 0;
        p_segments = 0;
        clear_session_flags();
        gen_ms = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset configuration.
        queue_directed();
        wait_drained();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_RETRY, 16'd1);
                    write_reg(REG_TIMEOUT, 16'd1);
                    write_reg(REG_HELLO, 16'h0000);
                    write_reg(REG_UNUSED, 16'hFFFF);
                end
                1:
                begin
                    write_reg(REG_RETRY, 16'hFFFF);
                    write_reg(REG_TIMEOUT, 16'hFFFF);
                    write_reg(REG_HELLO, 16'hFFFF);
                    gen_ms = 32'hFFFF_0000 + $urandom_range(0, 255);
                end
                2:
                begin
                    write_reg(REG_RETRY, 16'($urandom_range(1, 3000)));
                    write_reg(REG_TIMEOUT, 16'($urandom_range(1, 300)));
                    write_reg(REG_HELLO, 16'($urandom));
                end
                default:
                begin
                    write_reg(REG_RETRY, 16'd2000);
                    write_reg(REG_TIMEOUT, 16'd5000);
                    write_reg(REG_HELLO, 16'h53AB);
                end
            endcase
            target = WORD_TARGET * (phase + 1) / 4;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_noise();
                else
                    queue_session();
            end
            if (phase == 1)
                hold_request = 1'b1;
            wait_drained();
        end

        $display("tb: %0d words, %0d hellos, %0d acks, %0d payloads delivered,",
                 words_sent, n_hello, n_ack, n_deliver);
        $display("tb: %0d duplicates and %0d stale-session drops over four settings",
                 n_dup, n_stale);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
